/* sv/oal_pkg.sv */
`timescale 1ns / 1ps
// oal_pkg: shared sizes, command codes and cell control types for the ordered array list
// no dependencies; imported by every module of the block

package oal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_LOCATE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_CLEAR,
        CELL_MATCH
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic [IDX_W-1:0]          pos_idx;
        logic [CNT_W-1:0]          count;
        logic signed [WORD_W-1:0]  value;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

/* sv/oal_cell.sv */
`timescale 1ns / 1ps
// oal_cell: one list slot; holds a word and shifts, loads, clears or compares it
// depends on oal_pkg

module oal_cell
    import oal_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [IDX_W-1:0]          cell_idx,
    input  cell_ctl_t                 ctl,
    input  logic signed [WORD_W-1:0]  left_data,
    input  logic signed [WORD_W-1:0]  right_data,
    output logic signed [WORD_W-1:0]  data,
    output logic                      match
);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     match_reg;
    logic                     match_next;
    logic [CNT_W-1:0]         idx_ext;

    assign idx_ext = CNT_W'(cell_idx);

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (ctl.cmd)
            CELL_INSERT:
            begin
                if (cell_idx == ctl.pos_idx)
                begin
                    data_next = ctl.value;
                end
                else if ((cell_idx > ctl.pos_idx) && (idx_ext <= ctl.count))
                begin
                    data_next = left_data;
                end
            end
            CELL_DELETE:
            begin
                if ((cell_idx >= ctl.pos_idx) && ((idx_ext + CNT_W'(1)) < ctl.count))
                begin
                    data_next = right_data;
                end
            end
            CELL_CLEAR:
            begin
                data_next = '0;
            end
            CELL_MATCH:
            begin
                match_next = (idx_ext < ctl.count) && (data_reg == ctl.value);
            end
            default:
            begin
                data_next  = data_reg;
                match_next = match_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg  <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            data_reg  <= data_next;
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

/* sv/ordered_array_list_unit.sv */
`timescale 1ns / 1ps
// ordered_array_list_unit: top level of the ordered list, a row of slot cells and its sequencer
// depends on oal_pkg and oal_cell

// A bounded list of up to 16 signed words with one-based positions, kept in a row of slot
// cells that all shift together toward or away from each other. A request passes through
// capture, cell update and result register, so its result is registered after the cell
// update. A locate also passes through a scan state before the result register, since the
// per-cell match flags are registered and then priority encoded in a state of their own.
// A new request is taken once the previous one has reached the output register, even while
// that result still waits for out_ready; a result that is not taken holds back the next one.
// Insert, delete and clear change the list in the cell update state; every result carries
// the list size and emptiness after the request.

module ordered_array_list_unit
    import oal_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OP_W-1:0]           operation,
    input  logic [POS_W-1:0]          position,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      ok,
    output logic signed [WORD_W-1:0]  word_out,
    output logic [POS_W-1:0]          found_position,
    output logic [POS_W-1:0]          list_size,
    output logic                      is_empty
);

    state_t                    state_reg;
    state_t                    state_next;

    logic [OP_W-1:0]           op_reg;
    logic [POS_W-1:0]          pos_reg;
    logic signed [WORD_W-1:0]  val_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      pend_ok_reg;
    logic                      pend_ok_next;
    logic signed [WORD_W-1:0]  pend_word_reg;
    logic signed [WORD_W-1:0]  pend_word_next;
    logic [POS_W-1:0]          pend_found_reg;
    logic [POS_W-1:0]          pend_found_next;

    logic                      out_valid_reg;
    logic                      ok_reg;
    logic signed [WORD_W-1:0]  word_reg;
    logic [POS_W-1:0]          found_reg;
    logic [POS_W-1:0]          size_reg;
    logic                      empty_reg;

    cell_ctl_t                 cell_ctl;
    logic signed [WORD_W-1:0]  cell_data [CAPACITY];
    logic [CAPACITY-1:0]       match_vec;

    logic                      in_fire;
    logic                      emit_go;
    logic                      ins_ok;
    logic                      acc_ok;
    logic [IDX_W-1:0]          pos_idx;
    logic signed [WORD_W-1:0]  read_word;
    logic [POS_W-1:0]          scan_found;

    // position range checks
    assign pos_idx = IDX_W'(pos_reg - POS_W'(1));
    assign ins_ok  = (pos_reg != '0)
                     && ({1'b0, pos_reg} <= ({1'b0, POS_W'(count_reg)} + (POS_W + 1)'(1)))
                     && (count_reg < CNT_W'(CAPACITY));
    assign acc_ok  = (pos_reg != '0) && ({1'b0, pos_reg} <= {1'b0, POS_W'(count_reg)});
    assign read_word = cell_data[pos_idx];

    // slot cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_data[i+1];
        end

        oal_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(i)),
            .ctl        (cell_ctl),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );
    end

    // first match wins
    always_comb
    begin
        scan_found = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                scan_found = POS_W'(i + 1);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_LOCATE)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready         = 1'b0;
        emit_go          = 1'b0;
        cell_ctl.cmd     = CELL_HOLD;
        cell_ctl.pos_idx = pos_idx;
        cell_ctl.count   = count_reg;
        cell_ctl.value   = val_reg;
        count_next       = count_reg;
        pend_ok_next     = pend_ok_reg;
        pend_word_next   = pend_word_reg;
        pend_found_next  = pend_found_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                pend_ok_next    = 1'b0;
                pend_word_next  = '0;
                pend_found_next = '0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (ins_ok)
                        begin
                            cell_ctl.cmd = CELL_INSERT;
                            count_next   = count_reg + CNT_W'(1);
                            pend_ok_next = 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (acc_ok)
                        begin
                            cell_ctl.cmd   = CELL_DELETE;
                            count_next     = count_reg - CNT_W'(1);
                            pend_ok_next   = 1'b1;
                            pend_word_next = read_word;
                        end
                    end
                    OP_READ:
                    begin
                        if (acc_ok)
                        begin
                            pend_ok_next   = 1'b1;
                            pend_word_next = read_word;
                        end
                    end
                    OP_LOCATE:
                    begin
                        cell_ctl.cmd = CELL_MATCH;
                    end
                    OP_CLEAR:
                    begin
                        cell_ctl.cmd = CELL_CLEAR;
                        count_next   = '0;
                        pend_ok_next = 1'b1;
                    end
                    default:
                    begin
                        cell_ctl.cmd = CELL_HOLD;
                    end
                endcase
            end
            ST_SCAN:
            begin
                pend_found_next = scan_found;
                pend_ok_next    = (scan_found != '0);
            end
            ST_EMIT:
            begin
                emit_go = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            val_reg <= value;
        end
        pend_ok_reg    <= pend_ok_next;
        pend_word_reg  <= pend_word_next;
        pend_found_reg <= pend_found_next;
        if (emit_go)
        begin
            ok_reg    <= pend_ok_reg;
            word_reg  <= pend_word_reg;
            found_reg <= pend_found_reg;
            size_reg  <= POS_W'(count_reg);
            empty_reg <= (count_reg == '0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign word_out       = word_reg;
    assign found_position = found_reg;
    assign list_size      = size_reg;
    assign is_empty       = empty_reg;

endmodule

/* sv/oal_checker.sv */
`timescale 1ns / 1ps
// oal_checker: port-level checks on results of the ordered list, bound to the top level
// depends on oal_pkg and ordered_array_list_unit

module oal_checker
    import oal_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      ok,
    input  logic signed [WORD_W-1:0]  word_out,
    input  logic [POS_W-1:0]          found_position,
    input  logic [POS_W-1:0]          list_size,
    input  logic                      is_empty
);

    // emptiness agrees with size
    a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (list_size == '0)))
        else $error("is_empty disagrees with list_size");

    // size never exceeds capacity
    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (list_size <= POS_W'(CAPACITY)))
        else $error("list_size above capacity");

    // a hit lies inside the list and is reported as success
    a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (found_position != '0)) |-> (ok && (found_position <= list_size)))
        else $error("found_position outside the list");

    // failed request carries no word
    a_fail_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (word_out == '0))
        else $error("failed request returned a word");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_out) && $stable(list_size)))
        else $error("stalled result changed");

endmodule

bind ordered_array_list_unit oal_checker u_oal_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .word_out       (word_out),
    .found_position (found_position),
    .list_size      (list_size),
    .is_empty       (is_empty)
);

/* sim/tb_ordered_array_list_unit.sv */
`timescale 1ns / 1ps
// tb_ordered_array_list_unit: self-checking testbench for the ordered array list unit
// depends on oal_pkg and ordered_array_list_unit; predicts each reply and checks it in order

module tb_ordered_array_list_unit;
    import oal_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam int RANDOM_CMDS   = 830;
    localparam int STALL_LIMIT   = 2000;
    localparam int STEADY_FIRST  = 400;
    localparam int STEADY_LAST   = 560;
    localparam int GAP_PERCENT   = 22;
    localparam int TRAIL_CYCLES  = 20;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] val;
        bit                       drain_first;
    } list_cmd_t;

    typedef struct {
        logic                     ok;
        logic signed [WORD_W-1:0] word;
        logic [POS_W-1:0]         found;
        logic [POS_W-1:0]         size;
        logic                     empty;
    } list_reply_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [OP_W-1:0]           operation = '0;
    logic [POS_W-1:0]          position = '0;
    logic signed [WORD_W-1:0]  value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      ok;
    logic signed [WORD_W-1:0]  word_out;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          list_size;
    logic                      is_empty;

    list_cmd_t   list_cmds_pending[$];
    list_reply_t predicted_replies[$];
    list_cmd_t   cur_cmd;
    list_reply_t got_reply;
    list_reply_t want_reply;

    // predictor state
    logic signed [WORD_W-1:0] model_store[CAPACITY];
    int model_count;

    // stimulus side tracking of the list length, for picking positions
    int gen_count;
    logic signed [WORD_W-1:0] recent_vals[8];
    int recent_wr;

    int  requests_sent;
    int  replies_checked;
    int  errors;
    int  stall_cycles;
    int  ops_seen[8];
    int  spare_seen;
    int  longest_list;
    int  full_refusals;
    bit  sender_gap;
    logic steady;

    assign steady = (requests_sent >= STEADY_FIRST) && (requests_sent < STEADY_LAST);

    ordered_array_list_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .word_out       (word_out),
        .found_position (found_position),
        .list_size      (list_size),
        .is_empty       (is_empty)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic list_reply_t apply_list_cmd(input list_cmd_t cmd);
        list_reply_t r;
        int p;
        r = '{ok: 1'b0, word: '0, found: '0, size: '0, empty: 1'b0};
        p = cmd.pos;
        case (cmd.op)
            OP_INSERT:
            begin
                if (model_count == CAPACITY)
                    full_refusals++;
                if (p >= 1 && p <= model_count + 1 && model_count < CAPACITY)
                begin
                    for (int j = model_count; j >= p; j--)
                        model_store[j] = model_store[j - 1];
                    model_store[p - 1] = cmd.val;
                    model_count++;
                    r.ok = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (p >= 1 && p <= model_count)
                begin
                    r.word = model_store[p - 1];
                    for (int j = p; j < model_count; j++)
                        model_store[j - 1] = model_store[j];
                    model_count--;
                    r.ok = 1'b1;
                end
            end
            OP_READ:
            begin
                if (p >= 1 && p <= model_count)
                begin
                    r.word = model_store[p - 1];
                    r.ok = 1'b1;
                end
            end
            OP_LOCATE:
            begin
                for (int j = 0; j < model_count; j++)
                begin
                    if (!r.ok && model_store[j] == cmd.val)
                    begin
                        r.found = POS_W'(j + 1);
                        r.ok = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (int j = 0; j < CAPACITY; j++)
                    model_store[j] = '0;
                model_count = 0;
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (model_count > longest_list)
            longest_list = model_count;
        r.size = POS_W'(model_count);
        r.empty = (model_count == 0);
        return r;
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input int pos,
                             input logic signed [WORD_W-1:0] val, input bit drain_first);
        list_cmd_t c;
        c.op = op;
        c.pos = POS_W'(pos);
        c.val = val;
        c.drain_first = drain_first;
        list_cmds_pending.push_back(c);
        if (op == OP_INSERT && pos >= 1 && pos <= gen_count + 1 && gen_count < CAPACITY)
        begin
            gen_count++;
            recent_vals[recent_wr] = val;
            recent_wr = (recent_wr + 1) % 8;
        end
        else if (op == OP_DELETE && pos >= 1 && pos <= gen_count)
            gen_count--;
        else if (op == OP_CLEAR)
            gen_count = 0;
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return $signed(WORD_W'($urandom_range(3)));
        else if (r < 20)
            return 32'sh7fffffff;
        else if (r < 25)
            return 32'sh80000000;
        else if (r < 30)
            return -32'sd1;
        return $signed($urandom);
    endfunction

    function automatic int pick_pos(input int top);
        if (top >= 1 && $urandom_range(99) < 85)
            return $urandom_range(top, 1);
        return $urandom_range(31);
    endfunction

    task automatic queue_random(input bit grow, input bit drain_first);
        int r;
        logic [OP_W-1:0] op;
        logic signed [WORD_W-1:0] val;
        int pos;
        r = $urandom_range(99);
        val = pick_word();
        pos = $urandom_range(31);
        if (r < 3)
            op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        else if (r < 5)
            op = OP_CLEAR;
        else if (r < (grow ? 65 : 20))
        begin
            op = OP_INSERT;
            pos = pick_pos(gen_count + 1);
        end
        else if (r < (grow ? 75 : 70))
        begin
            op = OP_DELETE;
            pos = pick_pos(gen_count);
        end
        else if (r < (grow ? 85 : 82))
        begin
            op = OP_READ;
            pos = pick_pos(gen_count);
        end
        else
        begin
            op = OP_LOCATE;
            if ($urandom_range(99) < 60)
                val = recent_vals[$urandom_range(7)];
        end
        queue_cmd(op, pos, val, drain_first);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= '0;
            position <= '0;
            value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_replies.push_back(apply_list_cmd(cur_cmd));
                ops_seen[cur_cmd.op]++;
                requests_sent++;
            end
            if (!in_valid || in_ready)
            begin
                sender_gap = !steady && ($urandom_range(99) < GAP_PERCENT);
                if (list_cmds_pending.size() > 0 && !sender_gap &&
                    !(list_cmds_pending[0].drain_first && predicted_replies.size() > 0))
                begin
                    cur_cmd = list_cmds_pending.pop_front();
                    in_valid <= 1'b1;
                    operation <= cur_cmd.op;
                    position <= cur_cmd.pos;
                    value <= cur_cmd.val;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= steady || ($urandom_range(99) >= GAP_PERCENT);
            if (out_valid && out_ready)
            begin
                got_reply = '{ok: ok, word: word_out, found: found_position,
                              size: list_size, empty: is_empty};
                if (predicted_replies.size() == 0)
                begin
                    $error("reply with no request outstanding");
                    errors++;
                end
                else
                begin
                    want_reply = predicted_replies.pop_front();
                    replies_checked++;
                    if (got_reply.ok !== want_reply.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want_reply.ok, got_reply.ok);
                        errors++;
                    end
                    if (got_reply.word !== want_reply.word)
                    begin
                        $error("word_out: expected %0d, got %0d", want_reply.word,
                               got_reply.word);
                        errors++;
                    end
                    if (got_reply.found !== want_reply.found)
                    begin
                        $error("found_position: expected %0d, got %0d", want_reply.found,
                               got_reply.found);
                        errors++;
                    end
                    if (got_reply.size !== want_reply.size)
                    begin
                        $error("list_size: expected %0d, got %0d", want_reply.size,
                               got_reply.size);
                        errors++;
                    end
                    if (got_reply.empty !== want_reply.empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want_reply.empty,
                               got_reply.empty);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        bit grow;
        for (int j = 0; j < CAPACITY; j++)
            model_store[j] = '0;
        for (int j = 0; j < 8; j++)
            recent_vals[j] = '0;
        model_count = 0;
        gen_count = 0;
        recent_wr = 0;
        requests_sent = 0;
        replies_checked = 0;
        errors = 0;
        stall_cycles = 0;
        longest_list = 0;
        full_refusals = 0;
        spare_seen = 0;
        for (int j = 0; j < 8; j++)
            ops_seen[j] = 0;

        // empty list refusals and bad positions
        queue_cmd(OP_READ, 1, '0, 1'b0);
        queue_cmd(OP_DELETE, 1, '0, 1'b0);
        queue_cmd(OP_LOCATE, 0, '0, 1'b0);
        queue_cmd(OP_INSERT, 0, 32'sd5, 1'b0);
        queue_cmd(OP_INSERT, 2, 32'sd5, 1'b0);
        // front, end and middle inserts with extreme words
        queue_cmd(OP_INSERT, 1, 32'sh80000000, 1'b0);
        queue_cmd(OP_INSERT, 2, 32'sh7fffffff, 1'b0);
        queue_cmd(OP_INSERT, 1, -32'sd1, 1'b0);
        queue_cmd(OP_INSERT, 2, 32'sh7fffffff, 1'b0);
        queue_cmd(OP_INSERT, 31, 32'sd9, 1'b0);
        queue_cmd(OP_READ, 1, '0, 1'b0);
        queue_cmd(OP_READ, 4, '0, 1'b0);
        queue_cmd(OP_READ, 5, '0, 1'b0);
        queue_cmd(OP_READ, 0, '0, 1'b0);
        // first match among duplicates
        queue_cmd(OP_LOCATE, 0, 32'sh7fffffff, 1'b0);
        queue_cmd(OP_DELETE, 3, '0, 1'b0);
        queue_cmd(OP_LOCATE, 0, 32'sh80000000, 1'b0);
        queue_cmd(OP_DELETE, 31, '0, 1'b0);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            queue_cmd(OP_W'(op), 31, -32'sd1, 1'b0);
        queue_cmd(OP_CLEAR, 0, '0, 1'b0);
        queue_cmd(OP_READ, 1, '0, 1'b0);
        queue_cmd(OP_LOCATE, 0, '0, 1'b0);

        grow = 1'b1;
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i % 48 == 47)
                grow = !grow;
            queue_random(grow, (i == 0) || (i % 200 == 199));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (list_cmds_pending.size() > 0 || in_valid || predicted_replies.size() > 0)
            @(posedge clk);
        repeat (TRAIL_CYCLES) @(posedge clk);
        if (predicted_replies.size() != 0)
        begin
            $error("%0d replies never arrived", predicted_replies.size());
            errors++;
        end

        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            spare_seen += ops_seen[op];

        $display("%0d replies checked: %0d insert, %0d delete, %0d read, %0d locate, %0d clear,",
                 replies_checked, ops_seen[OP_INSERT], ops_seen[OP_DELETE], ops_seen[OP_READ],
                 ops_seen[OP_LOCATE], ops_seen[OP_CLEAR]);
        $display("%0d unused codes; longest list %0d, %0d inserts refused on a full list",
                 spare_seen, longest_list, full_refusals);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
